FILE: hw/rtl/scm_pkg.sv
// Shared types and constants for the stereo correlation meter.
package scm_pkg;

  localparam int SampleBitsDefault = 24;
  localparam int MaxWindowDefault  = 65536;

  localparam int SampleWidth   = 24;
  localparam int CorrWidth     = 16;
  localparam int CountWidth    = 24;
  localparam int LenWidth      = 17;
  localparam int EnergyWidth   = 64;
  localparam int CfgIndexWidth = 2;
  localparam int QuotientBits  = 16;

  localparam logic [CfgIndexWidth-1:0] RegWindowLength = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegGateEnergy   = 2'd1;

  localparam logic [LenWidth-1:0]          WindowLengthReset = 17'd2400;
  localparam logic [EnergyWidth-1:0]       GateEnergyReset   = '0;
  localparam logic [CountWidth-1:0]        CountMax          = '1;
  localparam logic signed [CorrWidth-1:0]  CorrPosFull       = 16'sh7FFF;
  localparam logic signed [CorrWidth-1:0]  CorrNegFull       = 16'sh8000;

  typedef struct packed {
    logic signed [SampleWidth-1:0] left_sample;
    logic signed [SampleWidth-1:0] right_sample;
    logic                          clear_stats;
  } scm_in_t;

  typedef struct packed {
    logic signed [CorrWidth-1:0] corr_value;
    logic                        was_gated;
    logic                        is_negative;
    logic [CountWidth-1:0]       counted_windows;
    logic [CountWidth-1:0]       negative_windows;
    logic signed [CorrWidth-1:0] min_corr;
    logic signed [CorrWidth-1:0] max_corr;
  } scm_out_t;

  typedef struct packed {
    logic load;
    logic square;
    logic use_side;
    logic acc_mid;
    logic acc_side;
    logic check;
    logic prep;
    logic div_step;
    logic finish;
    logic update;
    logic publish;
  } scm_cmd_t;

  typedef struct packed {
    logic window_end;
    logic gated;
    logic out_free;
  } scm_status_t;

endpackage

FILE: hw/rtl/stereo_correlation_meter.sv
// Top level of the stereo correlation meter: controller, datapath and checks.
// A sample request runs through capture, two squarings on one multiplier, sum and check.
// A request that closes a counted window then runs prep, the one-bit-per-cycle divider,
// finish, update and publish; a gated one skips prep and the divider. Publish waits for the output register.
// Results sit in an output register; a new request is taken while a result waits.
// Synchronous active-low reset: sums, counts and window position cleared, min 32767,
// max -32768, window_length 2400, gate_energy 0, output empty.
module stereo_correlation_meter #(
  parameter int SAMPLE_BITS = scm_pkg::SampleBitsDefault,
  parameter int MAX_WINDOW  = scm_pkg::MaxWindowDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  scm_pkg::scm_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output scm_pkg::scm_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scm_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [scm_pkg::EnergyWidth-1:0]   cfg_data
);
  import scm_pkg::*;

  scm_cmd_t    cmd;
  scm_status_t status;

  assign cfg_ready = 1'b1;

  scm_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  scm_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one in progress");

  a_min_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.counted_windows != '0) |->
      ($signed(out_data.min_corr) <= $signed(out_data.max_corr)))
    else $error("min_corr above max_corr");

  a_gated_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.was_gated) |->
      (out_data.corr_value == '0 && !out_data.is_negative))
    else $error("gated window carries a correlation");

  a_negative_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_negative) |-> ($signed(out_data.corr_value) <= 0))
    else $error("negative window with positive correlation");

endmodule

FILE: hw/rtl/scm_datapath.sv
// Datapath: squaring, window sums, shift-subtract divider, statistics, output register.
module scm_datapath #(
  parameter int SAMPLE_BITS = scm_pkg::SampleBitsDefault,
  parameter int MAX_WINDOW  = scm_pkg::MaxWindowDefault
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  scm_pkg::scm_cmd_t                    cmd,
  output scm_pkg::scm_status_t                 status,
  input  scm_pkg::scm_in_t                     in_data,
  input  logic                                 cfg_valid,
  input  logic [scm_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [scm_pkg::EnergyWidth-1:0]      cfg_data,
  output logic                                 out_valid,
  output scm_pkg::scm_out_t                    out_data,
  input  logic                                 out_stall
);
  import scm_pkg::*;

  localparam int MagWidth  = SAMPLE_BITS + 1;
  localparam int ProdWidth = 2 * MagWidth;
  localparam logic [LenWidth-1:0] MaxWin = LenWidth'(MAX_WINDOW);

  logic signed [SAMPLE_BITS-1:0] left_r, right_r;
  logic [ProdWidth-1:0]          prod_r;
  logic [EnergyWidth-1:0]        mid_sum_r, side_sum_r;
  logic [LenWidth-1:0]           samples_r;
  logic [LenWidth-1:0]           win_len_r;
  logic [EnergyWidth-1:0]        gate_r;
  logic [CountWidth-1:0]         count_r, neg_count_r;
  logic signed [CorrWidth-1:0]   low_r, high_r, corr_r;
  logic [EnergyWidth-1:0]        div_m_r, div_s_r, rem_r, den_r;
  logic [QuotientBits-1:0]       quo_r;
  logic                          gated_r, neg_r, zero_r, sat_r;
  logic                          out_valid_r;
  scm_out_t                      out_data_r;

  logic signed [MagWidth-1:0] mid_w, side_w;
  logic [MagWidth-1:0]        mid_mag, side_mag, sq_sel;
  logic [ProdWidth-1:0]       sq_w;
  logic [EnergyWidth:0]       acc_w;
  logic [EnergyWidth-1:0]     acc_sum, acc_base;
  logic [LenWidth-1:0]        len_eff;
  logic [1:0]                 shift_w;
  logic [EnergyWidth-1:0]     rem2_w;
  logic [QuotientBits:0]      rounded_w, neg_val_w;
  logic signed [CorrWidth-1:0] corr_nxt;

  assign mid_w  = MagWidth'(left_r) + MagWidth'(right_r);
  assign side_w = MagWidth'(left_r) - MagWidth'(right_r);
  assign mid_mag  = mid_w[MagWidth-1]  ? MagWidth'(-mid_w)  : MagWidth'(mid_w);
  assign side_mag = side_w[MagWidth-1] ? MagWidth'(-side_w) : MagWidth'(side_w);
  assign sq_sel = cmd.use_side ? side_mag : mid_mag;
  assign sq_w   = ProdWidth'(sq_sel) * ProdWidth'(sq_sel);

  assign acc_base = cmd.acc_mid ? mid_sum_r : side_sum_r;
  assign acc_w    = {1'b0, acc_base} + (EnergyWidth + 1)'(prod_r);
  assign acc_sum  = acc_w[EnergyWidth] ? '1 : acc_w[EnergyWidth-1:0];

  always_comb begin
    if (win_len_r == '0) begin
      len_eff = LenWidth'(1);
    end else if (win_len_r > MaxWin) begin
      len_eff = MaxWin;
    end else begin
      len_eff = win_len_r;
    end
  end

  always_comb begin
    if (mid_sum_r[63] || side_sum_r[63]) begin
      shift_w = 2'd2;
    end else if (mid_sum_r[62] || side_sum_r[62]) begin
      shift_w = 2'd1;
    end else begin
      shift_w = 2'd0;
    end
  end

  assign rem2_w    = {rem_r[EnergyWidth-2:0], 1'b0};
  assign rounded_w = ({1'b0, quo_r} + (QuotientBits + 1)'(1)) >> 1;
  assign neg_val_w = (QuotientBits + 1)'(0) - rounded_w;

  always_comb begin
    if (gated_r || zero_r) begin
      corr_nxt = '0;
    end else if (sat_r) begin
      corr_nxt = neg_r ? CorrNegFull : CorrPosFull;
    end else if (neg_r) begin
      corr_nxt = $signed(neg_val_w[CorrWidth-1:0]);
    end else if (rounded_w > (QuotientBits + 1)'(CorrPosFull)) begin
      corr_nxt = CorrPosFull;
    end else begin
      corr_nxt = $signed(rounded_w[CorrWidth-1:0]);
    end
  end

  assign status.window_end = samples_r >= len_eff;
  assign status.gated      = mid_sum_r < gate_r;
  assign status.out_free   = !out_valid_r || !out_stall;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= WindowLengthReset;
      gate_r    <= GateEnergyReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegWindowLength: win_len_r <= cfg_data[LenWidth-1:0];
        RegGateEnergy:   gate_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // window sums and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_sum_r   <= '0;
      side_sum_r  <= '0;
      samples_r   <= '0;
      count_r     <= '0;
      neg_count_r <= '0;
      low_r       <= CorrPosFull;
      high_r      <= CorrNegFull;
    end else begin
      if (cmd.load && in_data.clear_stats) begin
        mid_sum_r   <= '0;
        side_sum_r  <= '0;
        samples_r   <= '0;
        count_r     <= '0;
        neg_count_r <= '0;
        low_r       <= CorrPosFull;
        high_r      <= CorrNegFull;
      end
      if (cmd.acc_mid) begin
        mid_sum_r <= acc_sum;
      end
      if (cmd.acc_side) begin
        side_sum_r <= acc_sum;
        if (samples_r != '1) begin
          samples_r <= samples_r + LenWidth'(1);
        end
      end
      if (cmd.update) begin
        mid_sum_r  <= '0;
        side_sum_r <= '0;
        samples_r  <= '0;
        if (!gated_r) begin
          if (count_r != CountMax) begin
            count_r <= count_r + CountWidth'(1);
          end
          if (neg_r && neg_count_r != CountMax) begin
            neg_count_r <= neg_count_r + CountWidth'(1);
          end
          if (corr_r < low_r) begin
            low_r <= corr_r;
          end
          if (corr_r > high_r) begin
            high_r <= corr_r;
          end
        end
      end
    end
  end

  // sample capture, squaring and divider payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_r  <= in_data.left_sample[SAMPLE_BITS-1:0];
      right_r <= in_data.right_sample[SAMPLE_BITS-1:0];
    end
    if (cmd.square) begin
      prod_r <= sq_w;
    end
    if (cmd.check) begin
      div_m_r <= mid_sum_r >> shift_w;
      div_s_r <= side_sum_r >> shift_w;
      gated_r <= status.gated;
      neg_r   <= mid_sum_r < side_sum_r;
      zero_r  <= (mid_sum_r == '0) && (side_sum_r == '0);
    end
    if (cmd.prep) begin
      rem_r <= neg_r ? div_s_r - div_m_r : div_m_r - div_s_r;
      den_r <= div_m_r + div_s_r;
      sat_r <= (div_m_r == '0) || (div_s_r == '0);
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      if (rem2_w >= den_r) begin
        rem_r <= rem2_w - den_r;
        quo_r <= {quo_r[QuotientBits-2:0], 1'b1};
      end else begin
        rem_r <= rem2_w;
        quo_r <= {quo_r[QuotientBits-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      corr_r <= corr_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data_r.corr_value       <= corr_r;
      out_data_r.was_gated        <= gated_r;
      out_data_r.is_negative      <= neg_r && !gated_r;
      out_data_r.counted_windows  <= count_r;
      out_data_r.negative_windows <= neg_count_r;
      out_data_r.min_corr         <= low_r;
      out_data_r.max_corr         <= high_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/scm_controller.sv
// Controller: sequences squaring, accumulation, window check, divide and publish.
module scm_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  scm_pkg::scm_status_t status,
  output scm_pkg::scm_cmd_t    cmd
);
  import scm_pkg::*;

  localparam int CntWidth = $clog2(QuotientBits);

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StSqMid   = 4'd1;
  localparam logic [3:0] StSqSide  = 4'd2;
  localparam logic [3:0] StAccum   = 4'd3;
  localparam logic [3:0] StCheck   = 4'd4;
  localparam logic [3:0] StPrep    = 4'd5;
  localparam logic [3:0] StDiv     = 4'd6;
  localparam logic [3:0] StFinish  = 4'd7;
  localparam logic [3:0] StUpdate  = 4'd8;
  localparam logic [3:0] StPublish = 4'd9;

  localparam logic [CntWidth-1:0] LastStep = CntWidth'(QuotientBits - 1);

  logic [3:0]          state_r, state_nxt;
  logic [CntWidth-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      StIdle: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = StSqMid;
        end
      end
      StSqMid: begin
        cmd.square = 1'b1;
        state_nxt  = StSqSide;
      end
      StSqSide: begin
        cmd.square   = 1'b1;
        cmd.use_side = 1'b1;
        cmd.acc_mid  = 1'b1;
        state_nxt    = StAccum;
      end
      StAccum: begin
        cmd.acc_side = 1'b1;
        state_nxt    = StCheck;
      end
      StCheck: begin
        cmd.check = 1'b1;
        if (!status.window_end) begin
          state_nxt = StIdle;
        end else if (status.gated) begin
          state_nxt = StFinish;
        end else begin
          state_nxt = StPrep;
        end
      end
      StPrep: begin
        cmd.prep  = 1'b1;
        step_nxt  = '0;
        state_nxt = StDiv;
      end
      StDiv: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + CntWidth'(1);
        if (step_r == LastStep) begin
          state_nxt = StFinish;
        end
      end
      StFinish: begin
        cmd.finish = 1'b1;
        state_nxt  = StUpdate;
      end
      StUpdate: begin
        cmd.update = 1'b1;
        state_nxt  = StPublish;
      end
      StPublish: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_stall = state_r != StIdle;

endmodule

FILE: tb/tb_stereo_correlation_meter.sv
// Self-checking testbench for the stereo correlation meter: queued sample driver,
// window correlation predictor and result monitor.
module tb_stereo_correlation_meter;
  import scm_pkg::*;

  localparam int DrainCycles = 60;
  localparam int unsigned CycleLimit = 400000;
  localparam int RandomPhaseItems = 200;
  localparam int ResetPhaseItems = 200;
  localparam logic [LenWidth-1:0] LenMax = 17'd65536;
  localparam logic [LenWidth-1:0] LenAll = 17'h1FFFF;
  localparam logic signed [SampleWidth-1:0] SampleMax = 24'sh7FFFFF;
  localparam logic signed [SampleWidth-1:0] SampleMin = 24'sh800000;
  localparam logic [CfgIndexWidth-1:0] RegSpareLow  = 2'd2;
  localparam logic [CfgIndexWidth-1:0] RegSpareHigh = 2'd3;

  typedef enum int {
    PairRandom, PairInPhase, PairAntiPhase, PairSmall, PairExtreme, PairNear
  } pair_kind_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  scm_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  scm_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [EnergyWidth-1:0] cfg_data = '0;

  stereo_correlation_meter dut (.*);

  scm_in_t pending_samples[$];
  scm_out_t expected_windows[$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned window_results = 0;
  int unsigned cycle_count = 0;

  // predictor copy of registers and state
  logic [LenWidth-1:0] window_len_reg;
  logic [EnergyWidth-1:0] gate_reg;
  logic [EnergyWidth-1:0] mid_sum;
  logic [EnergyWidth-1:0] side_sum;
  logic [LenWidth-1:0] window_pos;
  logic [CountWidth-1:0] counted_total;
  logic [CountWidth-1:0] negative_total;
  logic signed [CorrWidth-1:0] corr_low;
  logic signed [CorrWidth-1:0] corr_high;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_meter_stats();
    mid_sum = '0;
    side_sum = '0;
    window_pos = '0;
    counted_total = '0;
    negative_total = '0;
    corr_low = CorrPosFull;
    corr_high = CorrNegFull;
  endfunction

  function automatic logic [EnergyWidth-1:0] add_sat(input logic [EnergyWidth-1:0] a,
                                                     input logic [EnergyWidth-1:0] b);
    logic [EnergyWidth:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[EnergyWidth] ? '1 : t[EnergyWidth-1:0];
  endfunction

  function automatic logic [EnergyWidth-1:0] square_of(input logic [SampleWidth:0] v);
    logic [SampleWidth:0] m;
    m = v[SampleWidth] ? -v : v;
    return EnergyWidth'(m) * EnergyWidth'(m);
  endfunction

  // r = (M - S) / (M + S), rounded Q1.15
  function automatic logic signed [CorrWidth-1:0] ratio_q15(input logic [EnergyWidth-1:0] m_in,
                                                           input logic [EnergyWidth-1:0] s_in);
    logic [EnergyWidth-1:0] m, s, num, den, rem;
    logic [QuotientBits:0] q;
    bit neg;
    int i;
    m = m_in;
    s = s_in;
    if (m == 0 && s == 0) return '0;
    neg = m < s;
    while ((m >> 62) != 0 || (s >> 62) != 0) begin
      m = m >> 1;
      s = s >> 1;
    end
    num = neg ? s - m : m - s;
    den = m + s;
    if (den == 0) return '0;
    if (num >= den) return neg ? CorrNegFull : CorrPosFull;
    rem = num;
    q = '0;
    for (i = 0; i < QuotientBits; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    q = (q + 1'b1) >> 1;
    if (!neg && q > 17'd32767) q = 17'd32767;
    return neg ? CorrWidth'(-q) : CorrWidth'(q);
  endfunction

  function automatic bit take_sample(input scm_in_t s, output scm_out_t r);
    logic [SampleWidth:0] mid_v, side_v;
    int unsigned len;
    logic signed [CorrWidth-1:0] c;
    bit gated, neg;
    r = '0;
    if (s.clear_stats) clear_meter_stats();
    mid_v = {s.left_sample[SampleWidth-1], s.left_sample}
          + {s.right_sample[SampleWidth-1], s.right_sample};
    side_v = {s.left_sample[SampleWidth-1], s.left_sample}
           - {s.right_sample[SampleWidth-1], s.right_sample};
    mid_sum = add_sat(mid_sum, square_of(mid_v));
    side_sum = add_sat(side_sum, square_of(side_v));
    if (window_pos != LenAll) window_pos = window_pos + 1'b1;
    len = 32'(window_len_reg);
    if (len == 0) len = 1;
    if (len > MaxWindowDefault) len = MaxWindowDefault;
    if (window_pos < len) return 1'b0;
    gated = mid_sum < gate_reg;
    c = '0;
    neg = 1'b0;
    if (!gated) begin
      c = ratio_q15(mid_sum, side_sum);
      neg = mid_sum < side_sum;
      if (counted_total != CountMax) counted_total = counted_total + 1'b1;
      if (neg && negative_total != CountMax) negative_total = negative_total + 1'b1;
      if (c < corr_low) corr_low = c;
      if (c > corr_high) corr_high = c;
    end
    mid_sum = '0;
    side_sum = '0;
    window_pos = '0;
    r.corr_value = c;
    r.was_gated = gated;
    r.is_negative = neg;
    r.counted_windows = counted_total;
    r.negative_windows = negative_total;
    r.min_corr = corr_low;
    r.max_corr = corr_high;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH %s", msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic signed [63:0] got,
                               input logic signed [63:0] want);
    if (got !== want)
      flag_mismatch($sformatf("window %0d %s: got %0d, expected %0d",
                              window_results, name, got, want));
  endtask

  always @(posedge clk) begin : drive_samples
    scm_out_t predicted;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (take_sample(in_data, predicted)) expected_windows = {expected_windows, predicted};
      end
      if (in_valid && in_stall) begin
        // payload held while stalled
      end else if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_results
    scm_out_t want;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        window_results++;
        if (expected_windows.size() == 0) begin
          flag_mismatch($sformatf("window %0d: result with no window pending", window_results));
        end else begin
          want = expected_windows.pop_front();
          compare_field("corr_value", out_data.corr_value, want.corr_value);
          compare_field("was_gated", out_data.was_gated, want.was_gated);
          compare_field("is_negative", out_data.is_negative, want.is_negative);
          compare_field("counted_windows", out_data.counted_windows, want.counted_windows);
          compare_field("negative_windows", out_data.negative_windows, want.negative_windows);
          compare_field("min_corr", out_data.min_corr, want.min_corr);
          compare_field("max_corr", out_data.max_corr, want.max_corr);
        end
      end
    end
  end

  always @(posedge clk) begin : run_limit
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d windows pending", cycle_count,
               expected_windows.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [EnergyWidth-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      RegWindowLength: window_len_reg = val[LenWidth-1:0];
      RegGateEnergy: gate_reg = val;
      default: ;
    endcase
  endtask

  function automatic bit meter_busy();
    return pending_samples.size() != 0 || in_valid || expected_windows.size() != 0;
  endfunction

  task automatic wait_idle();
    while (meter_busy()) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  task automatic push_pair(input logic signed [SampleWidth-1:0] l,
                           input logic signed [SampleWidth-1:0] r, input logic clr);
    scm_in_t p;
    p = '{left_sample: l, right_sample: r, clear_stats: clr};
    pending_samples = {pending_samples, p};
  endtask

  function automatic logic signed [SampleWidth-1:0] pick_extreme();
    case ($urandom_range(4))
      0: return SampleMin;
      1: return SampleMax;
      2: return '0;
      3: return '1;
      default: return 24'sd1;
    endcase
  endfunction

  function automatic scm_in_t random_pair(input pair_kind_e kind, input bit allow_clear);
    scm_in_t p;
    logic signed [SampleWidth-1:0] a;
    a = SampleWidth'($urandom);
    p.clear_stats = allow_clear && ($urandom_range(99) < 2);
    case (kind)
      PairInPhase: begin
        p.left_sample = a;
        p.right_sample = a;
      end
      PairAntiPhase: begin
        p.left_sample = a;
        p.right_sample = -a;
      end
      PairSmall: begin
        p.left_sample = SampleWidth'(int'($urandom_range(32)) - 16);
        p.right_sample = SampleWidth'(int'($urandom_range(32)) - 16);
      end
      PairExtreme: begin
        p.left_sample = pick_extreme();
        p.right_sample = pick_extreme();
      end
      PairNear: begin
        p.left_sample = a;
        p.right_sample = a + SampleWidth'(int'($urandom_range(2048)) - 1024);
      end
      default: begin
        p.left_sample = SampleWidth'($urandom);
        p.right_sample = SampleWidth'($urandom);
      end
    endcase
    return p;
  endfunction

  // pauses queueing halfway until every queued sample is sent and every window result has come
  task automatic run_random(input int n, input bit allow_clear);
    pair_kind_e kind;
    int i;
    @(negedge clk);
    kind = PairRandom;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) kind = pair_kind_e'($urandom_range(5));
      pending_samples = {pending_samples, random_pair(kind, allow_clear)};
      if (i == n / 2) begin
        while (meter_busy()) @(negedge clk);
      end
    end
  endtask

  initial begin : main_sequence
    int ph;
    logic [EnergyWidth-1:0] gate_pick;
    window_len_reg = WindowLengthReset;
    gate_reg = GateEnergyReset;
    clear_meter_stats();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values: partial window, no result yet
    run_random(ResetPhaseItems, 1'b0);
    wait_idle();

    // directed, one sample per window
    write_reg(RegWindowLength, 64'd1);
    @(negedge clk);
    push_pair('0, '0, 1'b0);
    push_pair(SampleMax, SampleMax, 1'b0);
    push_pair(SampleMax, -SampleMax, 1'b0);
    push_pair(SampleMin, SampleMin, 1'b0);
    push_pair(SampleMin, SampleMax, 1'b0);
    push_pair(SampleMax, SampleMin, 1'b0);
    push_pair(24'sd1, '0, 1'b0);
    push_pair(24'sd1, 24'sd3, 1'b0);
    push_pair(24'sd1, -24'sd3, 1'b0);
    push_pair('0, 24'sd5, 1'b0);
    push_pair(24'sd100, -24'sd50, 1'b1);
    wait_idle();

    // gating, zero length, unmapped register indexes
    write_reg(RegWindowLength, 64'd0);
    write_reg(RegGateEnergy, 64'd1 << 40);
    write_reg(RegSpareLow, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(RegSpareHigh, 64'd3);
    @(negedge clk);
    push_pair('0, '0, 1'b0);
    push_pair(24'sd1000, 24'sd1000, 1'b0);
    push_pair(SampleMin, SampleMin, 1'b0);
    push_pair(SampleMax, -SampleMax, 1'b0);
    push_pair(24'sh400000, -24'sh100000, 1'b0);
    push_pair('0, '0, 1'b1);
    wait_idle();
    write_reg(RegGateEnergy, '1);
    @(negedge clk);
    push_pair(SampleMin, SampleMin, 1'b0);
    push_pair(SampleMax, SampleMax, 1'b0);
    wait_idle();

    // window length lowered below the current position
    write_reg(RegGateEnergy, '0);
    write_reg(RegWindowLength, 64'(LenMax));
    run_random(30, 1'b0);
    wait_idle();
    write_reg(RegWindowLength, 64'(LenAll));
    run_random(30, 1'b0);
    wait_idle();
    write_reg(RegWindowLength, 64'd4);
    run_random(5, 1'b0);
    wait_idle();

    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: set_idling(0, 0);
        1: set_idling(68, 0);
        2: set_idling(0, 68);
        default: set_idling(29, 29);
      endcase
      if (ph == 5) gate_pick = '1;
      else if (ph % 4 == 0) gate_pick = '0;
      else gate_pick = 64'd1 << $urandom_range(52, 20);
      write_reg(RegGateEnergy, gate_pick);
      write_reg(RegWindowLength, (ph == 2) ? 64'd1 : 64'($urandom_range(9, 1)));
      run_random(RandomPhaseItems, 1'b1);
      wait_idle();
    end

    if (expected_windows.size() != 0)
      flag_mismatch($sformatf("%0d windows never reported", expected_windows.size()));
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/scm_pkg.sv
hw/rtl/scm_datapath.sv
hw/rtl/scm_controller.sv
hw/rtl/stereo_correlation_meter.sv
tb/tb_stereo_correlation_meter.sv
